// ===== hw/rtl/range_sum_segment_tree_macros.svh =====
// assertion macros for the range sum segment tree rtl
`ifndef RANGE_SUM_SEGMENT_TREE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_MACROS_SVH

// same-cycle implication, checked on the rising edge of clock outside reset
`define RSST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rsst_pkg.sv =====
// types and constants shared by the range sum segment tree modules
package rsst_pkg;

   localparam int FUNC_W         = 1;
   localparam int POS_W          = 10;
   localparam int VALUE_W        = 32;
   localparam int RANGE_W        = 11;
   localparam int SUM_W          = 42;
   localparam int LEAVES_DEFAULT = 1024;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET   = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_QRUN,
      ST_QOUT
   } engine_state_type;

   // status the back end reports to the front end
   typedef struct packed {
      logic clearing;
   } engine_status_type;

endpackage

// ===== hw/rtl/rsst_front.sv =====
// front end: accepts requests, clips ranges and turns them into node commands
module rsst_front #(
   parameter int LEAVES = rsst_pkg::LEAVES_DEFAULT,
   parameter int CNT_W  = 12,
   parameter int CMD_W  = 1 + 2 * CNT_W + rsst_pkg::VALUE_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rsst_pkg::FUNC_W-1:0]        req_func,
   input  logic [rsst_pkg::POS_W-1:0]         req_position,
   input  logic signed [rsst_pkg::VALUE_W-1:0] req_new_value,
   input  logic [rsst_pkg::RANGE_W-1:0]       req_range_start,
   input  logic [rsst_pkg::RANGE_W-1:0]       req_range_end,
   input  rsst_pkg::engine_status_type        status,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output logic [CMD_W-1:0]                   cmd_data
);

   localparam int WIDE_W = ((rsst_pkg::RANGE_W > CNT_W) ? rsst_pkg::RANGE_W : CNT_W) + 1;

   logic [WIDE_W-1:0] leaves_w;
   logic [WIDE_W-1:0] pos_w;
   logic [WIDE_W-1:0] start_w;
   logic [WIDE_W-1:0] end_w;
   logic [WIDE_W-1:0] hi_leaf;
   logic              is_query;
   logic              set_in_range;
   logic              empty_range;
   logic [CNT_W-1:0]  node_a;
   logic [CNT_W-1:0]  node_b;
   logic              ready_ff;
   logic              ready_in;

   assign leaves_w = WIDE_W'(LEAVES);
   assign pos_w    = WIDE_W'(req_position);
   assign start_w  = WIDE_W'(req_range_start);
   assign end_w    = WIDE_W'(req_range_end);
   assign is_query = (rsst_pkg::func_type'(req_func) == rsst_pkg::FUNC_QUERY);

   // end past the leaves is clipped; an empty or inverted range collapses to zero
   assign hi_leaf      = (end_w > leaves_w) ? leaves_w : end_w;
   assign empty_range  = (start_w >= hi_leaf);
   assign set_in_range = (pos_w < leaves_w);

   always_comb begin
      if (is_query) begin
         node_a = empty_range ? '0 : CNT_W'(start_w + leaves_w);
         node_b = empty_range ? '0 : CNT_W'(hi_leaf + leaves_w);
      end else begin
         node_a = CNT_W'(pos_w + leaves_w);
         node_b = '0;
      end
   end

   // no item is taken while the tree memory is being cleared
   assign ready_in  = ~status.clearing;
   assign req_ready = cmd_ready & ready_ff;

   // a set outside the leaves is taken and dropped
   assign cmd_valid = req_valid & ready_ff & (is_query | set_in_range);
   assign cmd_data  = {is_query, node_a, node_b, req_new_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== hw/rtl/rsst_queue.sv =====
// short command queue between the front and back ends
module rsst_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = rsst_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff;
   logic [PTR_W-1:0]  wptr_in;
   logic [PTR_W-1:0]  rptr_ff;
   logic [PTR_W-1:0]  rptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rsst_engine.sv =====
// back end: tree memory, clearing pass, leaf update walk and range query walk
`include "range_sum_segment_tree_macros.svh"

module rsst_engine #(
   parameter int LEAVES = rsst_pkg::LEAVES_DEFAULT,
   parameter int NODE_W = 11,
   parameter int CNT_W  = NODE_W + 1,
   parameter int CMD_W  = 1 + 2 * CNT_W + rsst_pkg::VALUE_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  logic [CMD_W-1:0]                  cmd_data,
   output rsst_pkg::engine_status_type       status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rsst_pkg::SUM_W-1:0] rsp_range_sum
);

   localparam int NODES   = 2 * LEAVES;
   localparam int SUM_W   = rsst_pkg::SUM_W;
   localparam int VALUE_W = rsst_pkg::VALUE_W;

   rsst_pkg::engine_state_type state_ff;
   rsst_pkg::engine_state_type state_in;

   logic [SUM_W-1:0]   mem [NODES];
   logic [SUM_W-1:0]   rd_a_ff;
   logic [SUM_W-1:0]   rd_b_ff;
   logic               wr_en;
   logic [NODE_W-1:0]  wr_addr;
   logic [SUM_W-1:0]   wr_data;
   logic [NODE_W-1:0]  rd_addr_a;
   logic [NODE_W-1:0]  rd_addr_b;

   logic [NODE_W-1:0]  clr_ff;
   logic [NODE_W-1:0]  clr_in;
   logic [CNT_W-1:0]   node_ff;
   logic [CNT_W-1:0]   node_in;
   logic [CNT_W-1:0]   hi_ff;
   logic [CNT_W-1:0]   hi_in;
   logic [SUM_W-1:0]   val_ff;
   logic [SUM_W-1:0]   val_in;
   logic [SUM_W-1:0]   acc_ff;
   logic [SUM_W-1:0]   acc_in;
   logic               pend_a_ff;
   logic               pend_a_in;
   logic               pend_b_ff;
   logic               pend_b_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic [SUM_W-1:0]   rsp_sum_in;

   logic               cmd_is_query;
   logic [CNT_W-1:0]   cmd_node_a;
   logic [CNT_W-1:0]   cmd_node_b;
   logic [VALUE_W-1:0] cmd_value;
   logic [SUM_W-1:0]   leaf_value;
   logic               clr_done;
   logic [CNT_W-1:0]   parent;
   logic               root_reached;
   logic [SUM_W-1:0]   level_sum;
   logic               q_run;
   logic               issue_a;
   logic               issue_b;
   logic [CNT_W-1:0]   hi_m1;
   logic [SUM_W-1:0]   add_a;
   logic [SUM_W-1:0]   add_b;
   logic               out_free;

   assign cmd_is_query = cmd_data[CMD_W-1];
   assign cmd_node_a   = cmd_data[CMD_W-2 -: CNT_W];
   assign cmd_node_b   = cmd_data[VALUE_W +: CNT_W];
   assign cmd_value    = cmd_data[VALUE_W-1:0];
   assign leaf_value   = {{(SUM_W - VALUE_W){cmd_value[VALUE_W-1]}}, cmd_value};

   assign clr_done     = (clr_ff == NODE_W'(NODES - 1));
   assign parent       = node_ff >> 1;
   assign root_reached = (parent == CNT_W'(1));
   // the sibling read issued last cycle completes the parent sum
   assign level_sum    = val_ff + rd_a_ff;

   assign q_run   = (node_ff < hi_ff);
   assign issue_a = q_run & node_ff[0];
   assign issue_b = q_run & hi_ff[0];
   assign hi_m1   = hi_ff - 1'b1;
   assign add_a   = pend_a_ff ? rd_a_ff : '0;
   assign add_b   = pend_b_ff ? rd_b_ff : '0;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   assign cmd_ready       = (state_ff == rsst_pkg::ST_IDLE);
   assign status.clearing = (state_ff == rsst_pkg::ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_sum   = rsp_sum_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsst_pkg::ST_CLEAR: begin
            if (clr_done) begin
               state_in = rsst_pkg::ST_IDLE;
            end
         end
         rsst_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd_is_query ? rsst_pkg::ST_QRUN : rsst_pkg::ST_SET;
            end
         end
         rsst_pkg::ST_SET: begin
            if (root_reached) begin
               state_in = rsst_pkg::ST_IDLE;
            end
         end
         rsst_pkg::ST_QRUN: begin
            if (!q_run) begin
               state_in = rsst_pkg::ST_QOUT;
            end
         end
         rsst_pkg::ST_QOUT: begin
            if (out_free) begin
               state_in = rsst_pkg::ST_IDLE;
            end
         end
         default: state_in = rsst_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in       = clr_ff;
      node_in      = node_ff;
      hi_in        = hi_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      pend_a_in    = 1'b0;
      pend_b_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;
      unique case (state_ff)
         rsst_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         rsst_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               node_in = cmd_node_a;
               hi_in   = cmd_node_b;
               val_in  = leaf_value;
               acc_in  = '0;
               if (!cmd_is_query) begin
                  wr_en     = 1'b1;
                  wr_addr   = cmd_node_a[NODE_W-1:0];
                  wr_data   = leaf_value;
                  rd_addr_a = {cmd_node_a[NODE_W-1:1], ~cmd_node_a[0]};
               end
            end
         end
         rsst_pkg::ST_SET: begin
            wr_en     = 1'b1;
            wr_addr   = parent[NODE_W-1:0];
            wr_data   = level_sum;
            rd_addr_a = {parent[NODE_W-1:1], ~parent[0]};
            val_in    = level_sum;
            node_in   = parent;
         end
         rsst_pkg::ST_QRUN: begin
            // reads issued last level land now and are folded in
            acc_in    = acc_ff + add_a + add_b;
            rd_addr_a = node_ff[NODE_W-1:0];
            rd_addr_b = hi_m1[NODE_W-1:0];
            pend_a_in = issue_a;
            pend_b_in = issue_b;
            if (q_run) begin
               node_in = (node_ff + CNT_W'(issue_a)) >> 1;
               hi_in   = (hi_ff - CNT_W'(issue_b)) >> 1;
            end
         end
         rsst_pkg::ST_QOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      hi_ff      <= hi_in;
      val_ff     <= val_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RSST_ASSERT_NOW(a_query_bounds, state_ff == rsst_pkg::ST_QRUN, node_ff <= hi_ff, "query bounds crossed")
   `RSST_ASSERT_NOW(a_set_below_root, state_ff == rsst_pkg::ST_SET, node_ff > CNT_W'(1), "update walk passed the root")
   `RSST_ASSERT_NOW(a_no_rsp_in_clear, state_ff == rsst_pkg::ST_CLEAR, !rsp_valid_ff, "response during clear")
   `RSST_ASSERT_NEXT(a_set_no_rsp, state_ff == rsst_pkg::ST_SET && !rsp_valid_ff, !rsp_valid_ff, "set produced a response")

endmodule

// ===== hw/rtl/range_sum_segment_tree.sv =====
// top level of the range sum segment tree
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | func, position, new_value, range_start, range_end
//  rsp     | out       | rsp_valid/rsp_ready  | range_sum (queries only)
//
// a set writes the leaf and then walks up, writing each parent sum up to the root
// a query walks both range bounds up the tree level by level, then hands the sum to the output;
// the single-write, dual-read tree memory sets both walks
// after reset a clearing pass zeroes all 2*LEAVES memory nodes before any request is taken
// a two-entry command queue lets the front take requests while the back end walks or
// while a finished sum waits in the output register
module range_sum_segment_tree #(
   parameter int LEAVES = rsst_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsst_pkg::FUNC_W-1:0]         req_func,
   input  logic [rsst_pkg::POS_W-1:0]          req_position,
   input  logic signed [rsst_pkg::VALUE_W-1:0] req_new_value,
   input  logic [rsst_pkg::RANGE_W-1:0]        req_range_start,
   input  logic [rsst_pkg::RANGE_W-1:0]        req_range_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rsst_pkg::SUM_W-1:0]   rsp_range_sum
);

   localparam int NODE_W = $clog2(2 * LEAVES);
   localparam int CNT_W  = NODE_W + 1;
   localparam int CMD_W  = 1 + 2 * CNT_W + rsst_pkg::VALUE_W;

   rsst_pkg::engine_status_type status;

   logic             fr_valid;
   logic             fr_ready;
   logic [CMD_W-1:0] fr_data;
   logic             cmd_valid;
   logic             cmd_ready;
   logic [CMD_W-1:0] cmd_data;

   rsst_front #(
      .LEAVES (LEAVES),
      .CNT_W  (CNT_W),
      .CMD_W  (CMD_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .status          (status),
      .cmd_valid       (fr_valid),
      .cmd_ready       (fr_ready),
      .cmd_data        (fr_data)
   );

   rsst_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (rsst_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd_data)
   );

   rsst_engine #(
      .LEAVES (LEAVES),
      .NODE_W (NODE_W),
      .CNT_W  (CNT_W),
      .CMD_W  (CMD_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_data      (cmd_data),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_range_sum (rsp_range_sum)
   );

endmodule
